/* sv/spti_pkg.sv */
// Shared types, widths and codes for the sorted pick table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package spti_pkg;

    localparam int NUM_GATHERS_DEF = 64;
    localparam int MAX_PICKS_DEF   = 64;

    localparam int COORD_W    = 24;
    localparam int STEP_W     = 23;
    localparam int SCOUNT_W   = 17;
    localparam int SIDX_W     = 16;
    localparam int GIDX_W     = 6;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int LCOUNT_W   = 7;
    localparam int TI_W       = 40;
    localparam int DX_W       = TI_W + 1;
    localparam int PROD_W     = 66;
    localparam int QBITS      = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 40;

    localparam logic [QBITS-1:0] CAPQ = QBITS'(1) << (QBITS - 1);

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_DUP   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RANGE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd3;

    typedef enum logic [5:0] {
        S_IDLE, S_CHK, S_CLR, S_BAD, S_CNT, S_ROUTE, S_EMPTY, S_SIBAD,
        S_SC_RD, S_SC_CMP, S_DECIDE, S_RSETUP, S_ILOOP, S_SH_RD, S_SH_WR,
        S_PUT, S_CNT_WR, S_TI, S_RD0, S_E0_CHK, S_RDN, S_EN_CHK, S_BS_RD,
        S_BS_CHK, S_P0_RD, S_P1_RD, S_P1_CAP, S_TRIV_CHK, S_TRIV, S_MUL_LO,
        S_MUL_HI, S_DIV_INIT, S_OVF, S_DIV, S_SUM, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CNT_RD, OP_CLR, OP_BAD, OP_CNT_CAP, OP_EMPTY,
        OP_SIBAD, OP_SC_RD, OP_SC_CMP, OP_DECIDE, OP_RSETUP, OP_SH_RD,
        OP_SH_WR, OP_PUT, OP_CNT_WR, OP_TI, OP_RD0, OP_E0_CHK, OP_RDN,
        OP_EN_CHK, OP_BS_RD, OP_BS_CHK, OP_P0_RD, OP_P1_RD, OP_P1_CAP,
        OP_TRIV, OP_MUL_LO, OP_MUL_HI, OP_DIV_INIT, OP_OVF, OP_DIV
    } op_t;

    // SUM and OUT are separate flags beside the op enum in the command struct below.
    typedef struct packed {
        op_t  op;
        logic sum;
        logic out;
    } dp_cmd_t;

    typedef struct packed {
        logic req_clear;
        logic req_add;
        logic req_query;
        logic g_bad;
        logic si_bad;
        logic n_zero;
        logic n_lt2;
        logic scan_last;
        logic skip_add;
        logic shift_more;
        logic e0_le;
        logic en_hit;
        logic bs_end;
        logic trivial;
        logic div_ovf;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

/* sv/spti_ctrl.sv */
// Sequencing state machine for the sorted pick table interpolator.
`timescale 1ns / 1ps
`default_nettype none
module spti_ctrl
    import spti_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_CHK;
            S_CHK: begin
                if (stat.req_clear)  state_next = S_CLR;
                else if (stat.g_bad) state_next = S_BAD;
                else                 state_next = S_CNT;
            end
            S_CLR, S_BAD, S_EMPTY, S_SIBAD, S_TRIV, S_SUM, S_CNT_WR:
                state_next = S_OUT;
            S_CNT:      state_next = S_ROUTE;
            S_ROUTE: begin
                if (stat.req_query) begin
                    if (stat.si_bad)     state_next = S_SIBAD;
                    else if (stat.n_lt2) state_next = S_OUT;
                    else                 state_next = S_TI;
                end else if (stat.n_zero) begin
                    state_next = stat.req_add ? S_PUT : S_EMPTY;
                end else begin
                    state_next = S_SC_RD;
                end
            end
            S_SC_RD:    state_next = S_SC_CMP;
            S_SC_CMP: begin
                if (stat.scan_last) state_next = stat.req_add ? S_DECIDE : S_RSETUP;
                else                state_next = S_SC_RD;
            end
            S_DECIDE:   state_next = stat.skip_add ? S_OUT : S_ILOOP;
            S_RSETUP:   state_next = S_ILOOP;
            S_ILOOP: begin
                if (stat.shift_more)   state_next = S_SH_RD;
                else if (stat.req_add) state_next = S_PUT;
                else                   state_next = S_CNT_WR;
            end
            S_SH_RD:    state_next = S_SH_WR;
            S_SH_WR:    state_next = S_ILOOP;
            S_PUT:      state_next = S_CNT_WR;
            S_TI:       state_next = S_RD0;
            S_RD0:      state_next = S_E0_CHK;
            S_E0_CHK:   state_next = stat.e0_le ? S_P0_RD : S_RDN;
            S_RDN:      state_next = S_EN_CHK;
            S_EN_CHK:   state_next = stat.en_hit ? S_P0_RD : S_BS_RD;
            S_BS_RD:    state_next = S_BS_CHK;
            S_BS_CHK:   state_next = stat.bs_end ? S_P0_RD : S_BS_RD;
            S_P0_RD:    state_next = S_P1_RD;
            S_P1_RD:    state_next = S_P1_CAP;
            S_P1_CAP:   state_next = S_TRIV_CHK;
            S_TRIV_CHK: state_next = stat.trivial ? S_TRIV : S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = S_OVF;
            S_OVF:      state_next = stat.div_ovf ? S_SUM : S_DIV;
            S_DIV:      state_next = stat.div_last ? S_SUM : S_DIV;
            S_OUT:      if (stat.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.sum  = 1'b0;
        cmd.out  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            S_CHK:      cmd.op = OP_CNT_RD;
            S_CLR:      cmd.op = OP_CLR;
            S_BAD:      cmd.op = OP_BAD;
            S_CNT:      cmd.op = OP_CNT_CAP;
            S_EMPTY:    cmd.op = OP_EMPTY;
            S_SIBAD:    cmd.op = OP_SIBAD;
            S_SC_RD:    cmd.op = OP_SC_RD;
            S_SC_CMP:   cmd.op = OP_SC_CMP;
            S_DECIDE:   cmd.op = OP_DECIDE;
            S_RSETUP:   cmd.op = OP_RSETUP;
            S_SH_RD:    cmd.op = OP_SH_RD;
            S_SH_WR:    cmd.op = OP_SH_WR;
            S_PUT:      cmd.op = OP_PUT;
            S_CNT_WR:   cmd.op = OP_CNT_WR;
            S_TI:       cmd.op = OP_TI;
            S_RD0:      cmd.op = OP_RD0;
            S_E0_CHK:   cmd.op = OP_E0_CHK;
            S_RDN:      cmd.op = OP_RDN;
            S_EN_CHK:   cmd.op = OP_EN_CHK;
            S_BS_RD:    cmd.op = OP_BS_RD;
            S_BS_CHK:   cmd.op = OP_BS_CHK;
            S_P0_RD:    cmd.op = OP_P0_RD;
            S_P1_RD:    cmd.op = OP_P1_RD;
            S_P1_CAP:   cmd.op = OP_P1_CAP;
            S_TRIV:     cmd.op = OP_TRIV;
            S_MUL_LO:   cmd.op = OP_MUL_LO;
            S_MUL_HI:   cmd.op = OP_MUL_HI;
            S_DIV_INIT: cmd.op = OP_DIV_INIT;
            S_OVF:      cmd.op = OP_OVF;
            S_DIV:      cmd.op = OP_DIV;
            S_SUM:      cmd.sum = 1'b1;
            S_OUT:      cmd.out = stat.out_free;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

/* sv/spti_dp.sv */
// Datapath: configuration, pick and count memories, search, shift and interpolation.
`timescale 1ns / 1ps
`default_nettype none
module spti_dp
    import spti_pkg::*;
#(
    parameter int NUM_GATHERS = NUM_GATHERS_DEF,
    parameter int MAX_PICKS   = MAX_PICKS_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire [S_TDATA_W-1:0]   s_tdata,
    input  wire [REQ_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    localparam int SLOTS   = NUM_GATHERS * MAX_PICKS;
    localparam int A_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int G_W     = (NUM_GATHERS > 1) ? $clog2(NUM_GATHERS) : 1;
    localparam int N_W     = $clog2(MAX_PICKS + 1);
    localparam int ENTRY_W = 2 * COORD_W;
    localparam int BIT_W   = $clog2(QBITS);
    localparam int SUM_W   = QBITS + 2;

    // Configuration registers.
    logic                       key_sel_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [COORD_W-1:0]  origin_reg;
    logic [SCOUNT_W-1:0]        scount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_sel_reg <= 1'b0;
            step_reg    <= STEP_W'(256);
            origin_reg  <= '0;
            scount_reg  <= SCOUNT_W'(1024);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_SELECT:    key_sel_reg <= cfg_wdata[0];
                CFG_SAMPLE_STEP:   step_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_SAMPLE_ORIGIN: origin_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_SAMPLE_COUNT:  scount_reg  <= cfg_wdata[SCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched item.
    logic [REQ_W-1:0]          req_reg;
    logic [GIDX_W-1:0]         g_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [SIDX_W-1:0]         si_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            req_reg <= s_tuser;
            g_reg   <= s_tdata[GIDX_W-1:0];
            x_reg   <= s_tdata[GIDX_W+COORD_W-1:GIDX_W];
            y_reg   <= s_tdata[GIDX_W+2*COORD_W-1:GIDX_W+COORD_W];
            si_reg  <= s_tdata[GIDX_W+2*COORD_W+SIDX_W-1:GIDX_W+2*COORD_W];
        end
    end

    logic [31:0]     g_ext;
    logic [G_W-1:0]  g_idx;
    logic [A_W-1:0]  base;
    logic signed [COORD_W-1:0] k_in;

    assign g_ext = 32'(g_reg);
    assign g_idx = g_ext[G_W-1:0];
    assign base  = A_W'(g_ext * 32'(MAX_PICKS));
    assign k_in  = key_sel_reg ? y_reg : x_reg;

    // Count memory with a valid flag per gather, so that clear drops every list count at once.
    logic [N_W-1:0]         cnt_mem [NUM_GATHERS];
    logic [NUM_GATHERS-1:0] cvld_reg;
    logic [N_W-1:0]         cnt_rd_reg;
    logic                   cnt_vld_reg;
    logic [N_W-1:0]         n_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CNT_RD) begin
            cnt_rd_reg  <= cnt_mem[g_idx];
            cnt_vld_reg <= cvld_reg[g_idx];
        end
        if (cmd.op == OP_CNT_WR) begin
            cnt_mem[g_idx] <= n_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvld_reg <= '0;
        end else if (cmd.op == OP_CLR) begin
            cvld_reg <= '0;
        end else if (cmd.op == OP_CNT_WR) begin
            cvld_reg[g_idx] <= 1'b1;
        end
    end

    // Slot indices.
    logic [N_W-1:0] idx_reg, best_reg, pos_reg, seg_reg, lo_reg, hi_reg;
    logic [N_W:0]   lh_sum;
    logic [N_W-1:0] mid;
    logic [N_W-1:0] rd_slot, wr_slot;

    assign lh_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid    = lh_sum[N_W:1];

    always_comb begin
        priority case (cmd.op)
            OP_SC_RD: rd_slot = idx_reg;
            OP_SH_RD: rd_slot = stat.req_add ? idx_reg - 1'b1 : idx_reg + 1'b1;
            OP_RDN:   rd_slot = n_reg - 1'b1;
            OP_BS_RD: rd_slot = mid;
            OP_P0_RD: rd_slot = seg_reg;
            OP_P1_RD: rd_slot = seg_reg + 1'b1;
            default:  rd_slot = '0;
        endcase
    end

    assign wr_slot = (cmd.op == OP_PUT) ? pos_reg : idx_reg;

    // Pick memory: one entry per slot, {y, x}.
    logic [ENTRY_W-1:0] pick_mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [A_W-1:0]     rd_addr, wr_addr;
    logic               mem_we;

    assign rd_addr = base + A_W'(rd_slot);
    assign wr_addr = base + A_W'(wr_slot);
    assign mem_we  = (cmd.op == OP_PUT) || (cmd.op == OP_SH_WR);

    always_ff @(posedge aclk) begin
        rd_data_reg <= pick_mem[rd_addr];
        if (mem_we) begin
            pick_mem[wr_addr] <= (cmd.op == OP_PUT) ? {y_reg, x_reg} : rd_data_reg;
        end
    end

    logic signed [COORD_W-1:0] ent_x, ent_y, key_ent, val_ent;
    logic signed [TI_W-1:0]    key_ext;

    assign ent_x   = rd_data_reg[COORD_W-1:0];
    assign ent_y   = rd_data_reg[ENTRY_W-1:COORD_W];
    assign key_ent = key_sel_reg ? ent_y : ent_x;
    assign val_ent = key_sel_reg ? ent_x : ent_y;
    assign key_ext = TI_W'(key_ent);

    // Nearest-pick scan.
    logic signed [COORD_W:0]   kd;
    logic [COORD_W:0]          kd_abs;
    logic [COORD_W:0]          bd_reg;
    logic signed [COORD_W-1:0] bkey_reg;
    logic                      dup, full;

    assign kd     = (COORD_W+1)'(key_ent) - (COORD_W+1)'(k_in);
    assign kd_abs = kd[COORD_W] ? (COORD_W+1)'(-kd) : (COORD_W+1)'(kd);
    assign dup    = (k_in == bkey_reg);
    assign full   = (n_reg >= N_W'(MAX_PICKS));

    // Query arithmetic.
    logic signed [TI_W-1:0]    ti_reg;
    logic [SIDX_W+STEP_W-1:0]  ti_prod;
    logic signed [COORD_W-1:0] p0_reg, t0_reg;
    logic signed [COORD_W:0]   dt, dp;
    logic signed [DX_W-1:0]    dx;
    logic [COORD_W:0]          a_reg, c_reg;
    logic [DX_W-1:0]           b_reg;
    logic                      neg_reg;
    logic [45:0]               m_lo;
    logic [44:0]               m_hi;
    logic [PROD_W-1:0]         prod_reg, rem_reg, dshift, cap_lim;
    logic [QBITS-1:0]          q_reg, q_cap;
    logic [BIT_W-1:0]          bit_reg;
    logic signed [SUM_W-1:0]   vsum;
    logic signed [COORD_W-1:0] vsat;
    logic                      bs_hit, bs_gt;
    logic [N_W-1:0]            lo_n, hi_n, span;

    assign ti_prod = si_reg * step_reg;
    assign dt      = (COORD_W+1)'(key_ent) - (COORD_W+1)'(t0_reg);
    assign dp      = (COORD_W+1)'(val_ent) - (COORD_W+1)'(p0_reg);
    assign dx      = DX_W'(ti_reg) - DX_W'(t0_reg);
    assign m_lo    = a_reg * b_reg[20:0];
    assign m_hi    = a_reg * b_reg[DX_W-1:21];
    assign dshift  = PROD_W'(c_reg) << bit_reg;
    assign cap_lim = PROD_W'(c_reg) << QBITS;
    assign q_cap   = (q_reg > CAPQ) ? CAPQ : q_reg;
    assign vsum    = neg_reg ? SUM_W'(p0_reg) - SUM_W'(q_cap)
                             : SUM_W'(p0_reg) + SUM_W'(q_cap);
    assign vsat    = (vsum > SUM_W'(8388607))  ? COORD_W'(8388607) :
                     (vsum < -SUM_W'(8388608)) ? COORD_W'(-8388608) :
                                                  COORD_W'(vsum);
    assign bs_hit  = (ti_reg == key_ext);
    assign bs_gt   = (ti_reg > key_ext);
    assign lo_n    = bs_gt ? mid : lo_reg;
    assign hi_n    = bs_gt ? hi_reg : mid;
    assign span    = hi_n - lo_n;

    // Result registers.
    logic [STATUS_W-1:0]       res_status;
    logic signed [COORD_W-1:0] res_value;
    logic [N_W-1:0]            res_count;

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_CLR, OP_BAD: begin
                res_status <= (cmd.op == OP_BAD) ? STS_RANGE : STS_OK;
                res_value  <= '0;
                res_count  <= '0;
            end
            OP_CNT_CAP: begin
                n_reg      <= cnt_vld_reg ? cnt_rd_reg : '0;
                res_count  <= cnt_vld_reg ? cnt_rd_reg : '0;
                res_status <= STS_OK;
                res_value  <= '0;
                idx_reg    <= '0;
                pos_reg    <= '0;
            end
            OP_EMPTY: res_status <= STS_EMPTY;
            OP_SIBAD: res_status <= STS_RANGE;
            OP_SC_CMP: begin
                if (idx_reg == '0 || kd_abs < bd_reg) begin
                    bd_reg   <= kd_abs;
                    best_reg <= idx_reg;
                    bkey_reg <= key_ent;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            OP_DECIDE: begin
                res_status <= dup ? STS_DUP : (full ? STS_FULL : STS_OK);
                pos_reg    <= (k_in < bkey_reg) ? best_reg : best_reg + 1'b1;
                idx_reg    <= n_reg;
            end
            OP_RSETUP: begin
                n_reg   <= n_reg - 1'b1;
                idx_reg <= best_reg;
            end
            OP_SH_WR: idx_reg <= req_reg == REQ_ADD ? idx_reg - 1'b1 : idx_reg + 1'b1;
            OP_PUT:   n_reg <= n_reg + 1'b1;
            OP_CNT_WR: res_count <= n_reg;
            OP_TI:    ti_reg <= TI_W'(ti_prod) + TI_W'(origin_reg);
            OP_E0_CHK: seg_reg <= '0;
            OP_EN_CHK: begin
                seg_reg <= n_reg - N_W'(2);
                lo_reg  <= '0;
                hi_reg  <= n_reg - 1'b1;
            end
            OP_BS_CHK: begin
                seg_reg <= bs_hit ? mid : lo_n;
                lo_reg  <= lo_n;
                hi_reg  <= hi_n;
            end
            OP_P1_RD: begin
                p0_reg <= val_ent;
                t0_reg <= key_ent;
            end
            OP_P1_CAP: begin
                a_reg   <= dp[COORD_W] ? (COORD_W+1)'(-dp) : (COORD_W+1)'(dp);
                c_reg   <= dt[COORD_W] ? (COORD_W+1)'(-dt) : (COORD_W+1)'(dt);
                b_reg   <= dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
                neg_reg <= dp[COORD_W] ^ dt[COORD_W] ^ dx[DX_W-1];
            end
            OP_TRIV:     res_value <= p0_reg;
            OP_MUL_LO:   prod_reg <= PROD_W'(m_lo);
            OP_MUL_HI:   prod_reg <= prod_reg + (PROD_W'(m_hi) << 21);
            OP_DIV_INIT: begin
                rem_reg <= prod_reg + PROD_W'(c_reg >> 1);
                bit_reg <= BIT_W'(QBITS - 1);
            end
            OP_OVF: q_reg <= (rem_reg >= cap_lim) ? CAPQ : '0;
            OP_DIV: begin
                if (rem_reg >= dshift) begin
                    rem_reg        <= rem_reg - dshift;
                    q_reg[bit_reg] <= 1'b1;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            default: ;
        endcase
        if (cmd.sum) begin
            res_value <= vsat;
        end
    end

    // Output register: holds one result beat until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.out) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out) begin
            m_tdata <= M_TDATA_W'({LCOUNT_W'(res_count), res_value, res_status});
        end
    end

    always_comb begin
        stat.req_clear  = (req_reg == REQ_CLEAR);
        stat.req_add    = (req_reg == REQ_ADD);
        stat.req_query  = (req_reg == REQ_QUERY);
        stat.g_bad      = (g_ext >= 32'(NUM_GATHERS));
        stat.si_bad     = (SCOUNT_W'(si_reg) >= scount_reg);
        stat.n_zero     = (n_reg == '0);
        stat.n_lt2      = (n_reg < N_W'(2));
        stat.scan_last  = (idx_reg == n_reg - 1'b1);
        stat.skip_add   = dup || full;
        stat.shift_more = (req_reg == REQ_ADD) ? (idx_reg > pos_reg) : (idx_reg < n_reg);
        stat.e0_le      = (ti_reg <= key_ext);
        stat.en_hit     = (ti_reg >= key_ext);
        stat.bs_end     = bs_hit || (span < N_W'(2));
        stat.trivial    = (a_reg == '0) || (b_reg == '0) || (c_reg == '0);
        stat.div_ovf    = (rem_reg >= cap_lim);
        stat.div_last   = (bit_reg == '0);
        stat.out_free   = !m_tvalid || m_tready;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_CNT_WR |-> n_reg <= N_W'(MAX_PICKS))
        else $error("pick count above list capacity");

    a_put_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUT |-> n_reg < N_W'(MAX_PICKS))
        else $error("insert into a full list");

    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_CLR |=> cvld_reg == '0)
        else $error("clear left a list count valid");

endmodule
`default_nettype wire

/* sv/sorted_pick_table_interpolator.sv */
// Top level of the sorted pick table interpolator: controller plus datapath.
//
// Usage. Each beat on the s_ channel is one request: add a pick, remove the
// nearest pick, interpolate at a grid sample, or clear every list (s_tuser).
// Every request gives exactly one result beat on the m_ channel carrying a
// status, the interpolated value and the list's pick count afterwards.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// One request is worked at a time; s_tready is high only when the sequencer
// is idle. Add and remove first scan the list for the nearest pick, then
// shift the stored entries one at a time. A query checks the first and last
// keys, binary-searches the segment when neither bounds the sample, and
// takes its quotient from a 27-step restoring divider unless the result is
// trivial or saturates. The pick memory has separate read and write
// addresses. The result waits in an output register: a stalled receiver
// holds m_tvalid and m_tdata, and a new request may already be taken
// meanwhile.
// Reset empties all lists at once, returns the registers to their defaults
// and drops m_tvalid; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sorted_pick_table_interpolator
    import spti_pkg::*;
#(
    parameter int NUM_GATHERS = NUM_GATHERS_DEF,
    parameter int MAX_PICKS   = MAX_PICKS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_wdata,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // gather_index, pick_x, pick_y, sample_index, zero pad
    input  wire [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire [REQ_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // status, interp_value, list_count, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    spti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spti_dp #(
        .NUM_GATHERS (NUM_GATHERS),
        .MAX_PICKS   (MAX_PICKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

/* tb/tb_sorted_pick_table_interpolator.sv */
// Self-checking testbench for the sorted pick table interpolator.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_pick_table_interpolator;
    import spti_pkg::*;

    localparam int NG = NUM_GATHERS_DEF;
    localparam int NP = MAX_PICKS_DEF;
    localparam int CYCLE_LIMIT = 4000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    always #4 aclk = ~aclk;

    sorted_pick_table_interpolator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  value;
        logic [LCOUNT_W-1:0] count;
    } answer_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [GIDX_W-1:0] gather;
        int                px;
        int                py;
        int                si;
        bit                typed;
        answer_t           ans;
    } row_t;

    // Shadow copy of the pick lists and the registers.
    longint shadow_x [NG][NP];
    longint shadow_y [NG][NP];
    int     shadow_n [NG];
    bit     key_is_y;
    longint grid_step;
    longint grid_origin;
    longint grid_count;

    answer_t pending_answers[$];
    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  full_seen = 0;
    int  dup_seen = 0;
    bit  burst = 1'b0;
    longint cycles = 0;

    function automatic longint key_of(int g, int s);
        return key_is_y ? shadow_y[g][s] : shadow_x[g][s];
    endfunction

    function automatic longint val_of(int g, int s);
        return key_is_y ? shadow_x[g][s] : shadow_y[g][s];
    endfunction

    function automatic int nearest_slot(int g, longint k);
        int best = 0;
        longint bd;
        longint d;
        bd = key_of(g, 0) - k;
        if (bd < 0) bd = -bd;
        for (int i = 1; i < shadow_n[g]; i++) begin
            d = key_of(g, i) - k;
            if (d < 0) d = -d;
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        return best;
    endfunction

    // Straight line through two picks; the quotient is rounded half away from zero.
    function automatic longint line_value(longint p0, longint p1, longint t0, longint t1,
                                          longint ti);
        longint dt = t1 - t0;
        longint dp = p1 - p0;
        longint dx = ti - t0;
        bit neg = 1'b0;
        longint unsigned a, b, c, hi, q1, r1, q;
        if (dt == 0) return p0;
        if (dp < 0) begin neg ^= 1'b1; dp = -dp; end
        if (dx < 0) begin neg ^= 1'b1; dx = -dx; end
        if (dt < 0) begin neg ^= 1'b1; dt = -dt; end
        a = dp;
        b = dx;
        c = dt;
        if (a == 0 || b == 0) return p0;
        hi = a * (b >> 20);
        q1 = hi / c;
        r1 = hi % c;
        if (q1 >= 64) begin
            q = 64'd1 << 26;
        end else begin
            q = (q1 << 20) + ((r1 << 20) + a * (b & 64'hFFFFF) + c / 2) / c;
            if (q > (64'd1 << 26)) q = 64'd1 << 26;
        end
        return neg ? p0 - longint'(q) : p0 + longint'(q);
    endfunction

    function automatic int find_segment(int g, longint ti);
        int lo = 0;
        int hi = shadow_n[g] - 1;
        int mid;
        if (ti <= key_of(g, 0)) return 0;
        if (ti >= key_of(g, hi)) return hi;
        while (1) begin
            mid = (hi + lo) / 2;
            if (ti == key_of(g, mid)) return mid;
            if (ti > key_of(g, mid)) lo = mid; else hi = mid;
            if (hi - lo < 2) return lo;
        end
    endfunction

    function automatic answer_t apply_request(logic [REQ_W-1:0] req, int g, longint x,
                                              longint y, longint si);
        answer_t r;
        int n, pos, m, seg;
        longint k, km, ti, v;
        r.status = STS_OK;
        r.value = '0;
        v = 0;
        if (req == REQ_CLEAR) begin
            for (int i = 0; i < NG; i++) shadow_n[i] = 0;
            n = 0;
        end else begin
            n = shadow_n[g];
            k = key_is_y ? y : x;
            if (req == REQ_ADD) begin
                pos = 0;
                if (n > 0) begin
                    m = nearest_slot(g, k);
                    km = key_of(g, m);
                    if (k == km) r.status = STS_DUP;
                    else if (n >= NP) r.status = STS_FULL;
                    else pos = (k < km) ? m : m + 1;
                end
                if (r.status == STS_OK) begin
                    for (int i = n; i > pos; i--) begin
                        shadow_x[g][i] = shadow_x[g][i-1];
                        shadow_y[g][i] = shadow_y[g][i-1];
                    end
                    shadow_x[g][pos] = x;
                    shadow_y[g][pos] = y;
                    n++;
                end
            end else if (req == REQ_REMOVE) begin
                if (n == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    m = nearest_slot(g, k);
                    n--;
                    for (int i = m; i < n; i++) begin
                        shadow_x[g][i] = shadow_x[g][i+1];
                        shadow_y[g][i] = shadow_y[g][i+1];
                    end
                end
            end else begin
                if (si >= grid_count) begin
                    r.status = STS_RANGE;
                end else if (n >= 2) begin
                    ti = si * grid_step + grid_origin;
                    if (ti <= key_of(g, 0)) seg = 0;
                    else if (ti > key_of(g, n - 1)) seg = n - 2;
                    else begin
                        seg = find_segment(g, ti);
                        if (seg > n - 2) seg = n - 2;
                    end
                    v = line_value(val_of(g, seg), val_of(g, seg + 1),
                                   key_of(g, seg), key_of(g, seg + 1), ti);
                    if (v > 8388607) v = 8388607;
                    if (v < -8388608) v = -8388608;
                end
            end
            shadow_n[g] = n;
        end
        r.value = v[COORD_W-1:0];
        r.count = n[LCOUNT_W-1:0];
        return r;
    endfunction

    // Leaves cfg_we high; the caller drops it after its last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            CFG_KEY_SELECT:    key_is_y = val[0];
            CFG_SAMPLE_STEP:   grid_step = val & 64'h7FFFFF;
            CFG_SAMPLE_ORIGIN: grid_origin = longint'($signed(val[23:0]));
            CFG_SAMPLE_COUNT:  grid_count = val & 64'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic send_item(row_t row);
        int gap;
        answer_t predicted;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= row.req;
        s_tdata <= {2'b00, row.si[15:0], row.py[23:0], row.px[23:0], row.gather};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(row.req, row.gather, longint'($signed(row.px[23:0])),
                                  longint'($signed(row.py[23:0])), row.si);
        pending_answers.push_back(row.typed ? row.ans : predicted);
        items_sent++;
    endtask

    function automatic int random_coord();
        int pick = $urandom_range(0, 99);
        if (pick < 60) return $urandom_range(0, 70000) - 4096;
        if (pick < 70) return pick[0] ? -8388608 : 8388607;
        return int'($signed(24'($urandom())));
    endfunction

    // Mostly adds and queries on a few gathers so that lists fill up.
    function automatic row_t random_row(int add_bias);
        row_t row;
        int pick = $urandom_range(0, 99);
        row.typed = 1'b0;
        row.ans = '{default: '0};
        if (pick < add_bias) row.req = REQ_ADD;
        else if (pick < add_bias + 15) row.req = REQ_REMOVE;
        else if (pick < 99) row.req = REQ_QUERY;
        else row.req = REQ_CLEAR;
        row.gather = ($urandom_range(0, 9) < 8) ? GIDX_W'($urandom_range(0, 2))
                                                 : GIDX_W'($urandom());
        row.px = random_coord();
        row.py = random_coord();
        if ($urandom_range(0, 4) == 0 || grid_count > 65536) row.si = $urandom_range(0, 65535);
        else row.si = $urandom_range(0, int'(grid_count) - 1);
        return row;
    endfunction

    // Result side: random stalls, then accept one beat.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL sorted_pick_table_interpolator");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[2:0] == STS_FULL) full_seen++;
            if (m_tdata[2:0] == STS_DUP) dup_seen++;
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[2:0] !== want.status || m_tdata[26:3] !== want.value ||
                    m_tdata[33:27] !== want.count) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected status %0d value %0d count %0d, got %0d %0d %0d",
                                 results_seen, want.status, $signed(want.value), want.count,
                                 m_tdata[2:0], $signed(m_tdata[26:3]), m_tdata[33:27]);
                end
            end
        end
    end

    row_t directed[$];

    function automatic row_t mk(logic [REQ_W-1:0] req, int g, int px, int py, int si,
                                bit typed, logic [STATUS_W-1:0] st, int val, int cnt);
        row_t row;
        row.req = req;
        row.gather = g[GIDX_W-1:0];
        row.px = px;
        row.py = py;
        row.si = si;
        row.typed = typed;
        row.ans.status = st;
        row.ans.value = val[COORD_W-1:0];
        row.ans.count = cnt[LCOUNT_W-1:0];
        return row;
    endfunction

    initial begin
        longint phase_cfg [5][4] = '{
            '{0, 256, 0, 1024},
            '{1, 8388607, -8388608, 65536},
            '{0, 0, 8388607, 1},
            '{1, 1, -4096, 300},
            '{0, 17, 100, 65535}
        };
        for (int i = 0; i < NG; i++) shadow_n[i] = 0;
        key_is_y = 1'b0;
        grid_step = 256;
        grid_origin = 0;
        grid_count = 1024;

        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 1, STS_OK, 0, 0));
        directed.push_back(mk(REQ_REMOVE, 0, 0, 0, 0, 1, STS_EMPTY, 0, 0));
        directed.push_back(mk(REQ_ADD, 0, -8388608, 8388607, 0, 1, STS_OK, 0, 1));
        directed.push_back(mk(REQ_ADD, 0, -8388608, 5, 0, 1, STS_DUP, 0, 1));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 5, 1, STS_OK, 0, 1));
        directed.push_back(mk(REQ_ADD, 0, 8388607, -8388608, 0, 1, STS_OK, 0, 2));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 1023, 0, STS_OK, 0, 0));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 1024, 1, STS_RANGE, 0, 2));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 65535, 1, STS_RANGE, 0, 2));
        directed.push_back(mk(REQ_ADD, 0, 0, 0, 0, 1, STS_OK, 0, 3));
        directed.push_back(mk(REQ_ADD, 0, 256, 8388607, 0, 1, STS_OK, 0, 4));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 0, STS_OK, 0, 0));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 1, 0, STS_OK, 0, 0));
        directed.push_back(mk(REQ_ADD, 1, 100, 100, 0, 1, STS_OK, 0, 1));
        directed.push_back(mk(REQ_ADD, 1, 100, -7, 0, 1, STS_DUP, 0, 1));
        directed.push_back(mk(REQ_ADD, 1, 300, -8388608, 0, 1, STS_OK, 0, 2));
        directed.push_back(mk(REQ_QUERY, 1, 0, 0, 0, 0, STS_OK, 0, 0));
        directed.push_back(mk(REQ_QUERY, 1, 0, 0, 1000, 0, STS_OK, 0, 0));
        directed.push_back(mk(REQ_REMOVE, 0, 300, 0, 0, 1, STS_OK, 0, 3));
        directed.push_back(mk(REQ_ADD, 63, 5, -3, 0, 1, STS_OK, 0, 1));
        directed.push_back(mk(REQ_CLEAR, 5, 0, 0, 0, 1, STS_OK, 0, 0));
        directed.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 1, STS_OK, 0, 0));
        directed.push_back(mk(REQ_REMOVE, 63, 0, 0, 0, 1, STS_EMPTY, 0, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_item(directed[i]);
        s_tvalid <= 1'b0;

        // Each phase waits for the block to go idle, then sets new registers.
        for (int p = 0; p < 5; p++) begin
            drain();
            for (int r = 0; r < 4; r++) write_reg(CFG_IDX_W'(r), phase_cfg[p][r]);
            if (p == 2) write_reg(3'd7, 24'hABCDEF);
            cfg_we <= 1'b0;
            for (int i = 0; i < 260; i++) begin
                if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
                send_item(random_row((p % 2 == 0) ? 70 : 45));
            end
            burst = 1'b0;
            s_tvalid <= 1'b0;
        end

        drain();
        $display("%0d requests sent, %0d results checked over 5 register settings",
                 items_sent, results_seen);
        $display("full-list results %0d, duplicate-key results %0d, mismatches %0d",
                 full_seen, dup_seen, errors);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("PASS sorted_pick_table_interpolator");
        end else begin
            $display("FAIL sorted_pick_table_interpolator");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sorted_pick_table_interpolator.f */
sv/spti_pkg.sv
sv/spti_ctrl.sv
sv/spti_dp.sv
sv/sorted_pick_table_interpolator.sv
tb/tb_sorted_pick_table_interpolator.sv
